// ===== sv/spms_pkg.sv =====
// Shared types and constants for the shared-pool multi-stack block.
package spms_pkg;

   localparam int DATA_W = 32;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } seq_state_type;

   typedef struct packed {
      logic rd_en;
      logic link_we;
      logic data_we;
   } store_cmd_type;

   typedef struct packed {
      logic              done;
      logic              success;
      logic [DATA_W-1:0] pop_value;
   } result_type;

endpackage

// ===== sv/spms_store.sv =====
// Slot store: data and link memories with a fill mark for never-used slots.
module spms_store import spms_pkg::*; #(
   parameter int POOL_SLOTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  store_cmd_type                      cmd,
   input  logic [$clog2(POOL_SLOTS+1)-1:0]    rd_addr,
   input  logic [$clog2(POOL_SLOTS+1)-1:0]    wr_addr,
   input  logic [$clog2(POOL_SLOTS+1)-1:0]    wr_link,
   input  logic [DATA_W-1:0]                  wr_data,
   output logic [$clog2(POOL_SLOTS+1)-1:0]    rd_link,
   output logic [DATA_W-1:0]                  rd_data
);

   localparam int PTR_W = $clog2(POOL_SLOTS + 1);
   localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

   logic [PTR_W-1:0]  link_mem [POOL_SLOTS];
   logic [DATA_W-1:0] data_mem [POOL_SLOTS];

   logic [PTR_W-1:0]  link_q_ff;
   logic [DATA_W-1:0] data_q_ff;
   logic [PTR_W-1:0]  addr_ff;
   logic              fresh_ff;
   logic [PTR_W-1:0]  mark_ff;
   logic [PTR_W-1:0]  mark_in;

   // Slots at or above the mark were never handed out, so their link is
   // still the reset chain to the next slot and the memory is not consulted.
   assign rd_link = fresh_ff ? (addr_ff + PTR_W'(1)) : link_q_ff;
   assign rd_data = data_q_ff;

   always_comb begin
      mark_in = mark_ff;
      if (cmd.link_we && (wr_addr == mark_ff)) begin
         mark_in = mark_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         link_q_ff <= link_mem[rd_addr[IDX_W-1:0]];
         data_q_ff <= data_mem[rd_addr[IDX_W-1:0]];
         addr_ff   <= rd_addr;
         fresh_ff  <= (rd_addr >= mark_ff);
      end
      if (cmd.link_we) begin
         link_mem[wr_addr[IDX_W-1:0]] <= wr_link;
      end
      if (cmd.data_we) begin
         data_mem[wr_addr[IDX_W-1:0]] <= wr_data;
      end
   end

endmodule

// ===== sv/spms_seq.sv =====
// Sequencer: stack tops, free-list head and the two-step push/pop control.
module spms_seq import spms_pkg::*; #(
   parameter int POOL_SLOTS  = 64,
   parameter int STACK_COUNT = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               in_kind,
   input  logic [1:0]                         in_stack_index,
   input  logic [DATA_W-1:0]                  in_value,
   input  logic                               out_busy,
   output result_type                         result,
   output store_cmd_type                      cmd,
   output logic [$clog2(POOL_SLOTS+1)-1:0]    rd_addr,
   output logic [$clog2(POOL_SLOTS+1)-1:0]    wr_addr,
   output logic [$clog2(POOL_SLOTS+1)-1:0]    wr_link,
   output logic [DATA_W-1:0]                  wr_data,
   input  logic [$clog2(POOL_SLOTS+1)-1:0]    rd_link,
   input  logic [DATA_W-1:0]                  rd_data
);

   localparam int PTR_W     = $clog2(POOL_SLOTS + 1);
   localparam int TOP_DEPTH = (STACK_COUNT < 4) ? STACK_COUNT : 4;
   localparam int TIDX_W    = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
   localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_SLOTS);

   seq_state_type     state_ff, state_in;
   logic [PTR_W-1:0]  top_ff [TOP_DEPTH];
   logic [PTR_W-1:0]  free_head_ff, free_head_in;
   logic              kind_ff, kind_in;
   logic              ok_ff, ok_in;
   logic [TIDX_W-1:0] tidx_ff, tidx_in;
   logic [PTR_W-1:0]  slot_ff, slot_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              top_we;
   logic [PTR_W-1:0]  top_wval;
   logic              sel_ok;
   logic [TIDX_W-1:0] req_tidx;

   // Only stack indexes below the stack count address a real stack.
   assign sel_ok   = (32'(in_stack_index) < STACK_COUNT);
   assign req_tidx = sel_ok ? in_stack_index[TIDX_W-1:0] : '0;

   always_comb begin
      state_in     = state_ff;
      free_head_in = free_head_ff;
      kind_in      = kind_ff;
      ok_in        = ok_ff;
      tidx_in      = tidx_ff;
      slot_in      = slot_ff;
      value_in     = value_ff;
      in_ready     = 1'b0;
      cmd          = '0;
      rd_addr      = slot_ff;
      wr_addr      = slot_ff;
      wr_link      = free_head_ff;
      wr_data      = value_ff;
      top_we       = 1'b0;
      top_wval     = slot_ff;
      result       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            slot_in  = (in_kind == KIND_POP) ? top_ff[req_tidx] : free_head_ff;
            rd_addr  = slot_in;
            if (in_valid) begin
               kind_in    = in_kind;
               tidx_in    = req_tidx;
               value_in   = in_value;
               ok_in      = sel_ok && (slot_in != NIL);
               cmd.rd_en  = ok_in;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!out_busy) begin
               result.done    = 1'b1;
               result.success = ok_ff;
               state_in       = ST_IDLE;
               if (ok_ff) begin
                  cmd.link_we = 1'b1;
                  top_we      = 1'b1;
                  if (kind_ff == KIND_PUSH) begin
                     cmd.data_we  = 1'b1;
                     wr_link      = top_ff[tidx_ff];
                     top_wval     = slot_ff;
                     free_head_in = rd_link;
                  end else begin
                     wr_link          = free_head_ff;
                     top_wval         = rd_link;
                     free_head_in     = slot_ff;
                     result.pop_value = rd_data;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         for (int i = 0; i < TOP_DEPTH; i++) begin
            top_ff[i] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         if (top_we) begin
            top_ff[tidx_ff] <= top_wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      ok_ff    <= ok_in;
      tidx_ff  <= tidx_in;
      slot_ff  <= slot_in;
      value_ff <= value_in;
   end

endmodule

// ===== sv/shared_pool_multi_stack.sv =====
// Top level of the shared-pool multi-stack block with its result register.
//
//   Channel   Ports                                                        Direction
//   request   req_valid req_ready req_kind req_stack_index req_push_value  in
//   response  rsp_valid rsp_ready rsp_success rsp_pop_value                out
//
// Each word has an accept step and an execute step: the accept step reads the link
// and data memories at the chosen slot when the request can succeed, and the execute
// step writes the link back on success and loads the result register. The
// read-then-write on the link memory sets this split. Reset leaves every stack empty
// and all slots free at once; never-used slots are tracked by a fill mark, so no
// clearing pass runs. While a result waits in the output register a new request is
// still taken; it stalls in its execute step only until the waiting result leaves.
module shared_pool_multi_stack import spms_pkg::*; #(
   parameter int POOL_SLOTS  = 64,
   parameter int STACK_COUNT = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [1:0]         req_stack_index,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_success,
   output logic signed [31:0] rsp_pop_value
);

   localparam int PTR_W = $clog2(POOL_SLOTS + 1);

   store_cmd_type     cmd;
   result_type        result;
   logic [PTR_W-1:0]  rd_addr;
   logic [PTR_W-1:0]  wr_addr;
   logic [PTR_W-1:0]  wr_link;
   logic [DATA_W-1:0] wr_data;
   logic [PTR_W-1:0]  rd_link;
   logic [DATA_W-1:0] rd_data;
   logic              out_busy;

   logic              rsp_valid_ff;
   logic              rsp_success_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   assign out_busy = rsp_valid_ff && !rsp_ready;

   spms_seq #(
      .POOL_SLOTS  (POOL_SLOTS),
      .STACK_COUNT (STACK_COUNT)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_kind        (req_kind),
      .in_stack_index (req_stack_index),
      .in_value       (DATA_W'(req_push_value)),
      .out_busy       (out_busy),
      .result         (result),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .wr_link        (wr_link),
      .wr_data        (wr_data),
      .rd_link        (rd_link),
      .rd_data        (rd_data)
   );

   spms_store #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_link (wr_link),
      .wr_data (wr_data),
      .rd_link (rd_link),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_success_ff <= result.success;
         rsp_value_ff   <= result.pop_value;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_success   = rsp_success_ff;
   assign rsp_pop_value = $signed(rsp_value_ff);

endmodule
